[rtl/core/lpfp_pkg.sv]
// ----------------------------------------------------------------------------
// lpfp_pkg: shared types and constants of the length-prefixed frame parser
// Header layout, result field widths, stream packing and the result struct.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  // Header is 17 bytes: type, 4 length, 8 timestamp, 4 transaction id
  localparam int HDR_BYTES = 17;
  localparam int CNT_W     = $clog2(HDR_BYTES);

  // Last byte index of each header section
  localparam logic [CNT_W-1:0] CNT_TYPE     = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_LEN_END  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_TIME_END = CNT_W'(12);
  localparam logic [CNT_W-1:0] CNT_HDR_END  = CNT_W'(HDR_BYTES - 1);

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 32;
  localparam int TIME_W  = 64;
  localparam int TRANS_W = 32;
  localparam int SID_W   = 32;

  // Output tdata: type, length, timestamp, transaction id, stream tag, byte
  localparam int TDATA_W = BYTE_W + LEN_W + TIME_W + TRANS_W + SID_W + BYTE_W;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } lpfp_kind_t;

  typedef struct packed {
    lpfp_kind_t          kind;
    logic [BYTE_W-1:0]   packet_type;
    logic [LEN_W-1:0]    payload_length;
    logic [TIME_W-1:0]   timestamp;
    logic [TRANS_W-1:0]  transaction_id;
    logic [SID_W-1:0]    stream_tag;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last;
  } lpfp_result_t;

endpackage

[rtl/core/lpfp_in_stage.sv]
// ----------------------------------------------------------------------------
// lpfp_in_stage: input byte register
// Holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module lpfp_in_stage
  import lpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,    // data_byte [7:0]
  input  logic              take,
  output logic              in_valid,
  output logic [BYTE_W-1:0] in_byte
);

  // Accept while empty or while the held item moves on this cycle
  assign s_tready = !in_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

[rtl/core/lpfp_parser.sv]
// ----------------------------------------------------------------------------
// lpfp_parser: header collection and payload tracking
// Shifts header bytes into their fields, then counts payload bytes down.
// ----------------------------------------------------------------------------
module lpfp_parser
  import lpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [SID_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output lpfp_result_t      res
);

  logic               in_payload, in_payload_next;
  logic [CNT_W-1:0]   header_count, header_count_next;
  logic [BYTE_W-1:0]  type_reg, type_reg_next;
  logic [LEN_W-1:0]   length_reg, length_reg_next;
  logic [TIME_W-1:0]  time_reg, time_reg_next;
  logic [TRANS_W-1:0] trans_reg, trans_reg_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [SID_W-1:0]   sid_reg;
  logic               pay_mode;
  logic               hdr_done;
  logic               produces;

  // Classify the held byte
  assign pay_mode = in_payload && (remaining != '0);
  assign hdr_done = !pay_mode && (header_count == CNT_HDR_END);
  assign produces = pay_mode || hdr_done;

  // Consume the byte unless its result cannot be stored
  assign take      = in_valid && (out_free || !produces);
  assign res_valid = take && produces;

  // Next state and result
  always_comb begin
    in_payload_next   = in_payload;
    header_count_next = header_count;
    type_reg_next     = type_reg;
    length_reg_next   = length_reg;
    time_reg_next     = time_reg;
    trans_reg_next    = trans_reg;
    remaining_next    = remaining;

    if (pay_mode) begin
      remaining_next  = remaining - LEN_W'(1);
      in_payload_next = (remaining != LEN_W'(1));
    end else begin
      in_payload_next = 1'b0;
      if (header_count == CNT_TYPE) begin
        type_reg_next = in_byte;
      end else if (header_count <= CNT_LEN_END) begin
        length_reg_next = {length_reg[LEN_W-BYTE_W-1:0], in_byte};
      end else if (header_count <= CNT_TIME_END) begin
        time_reg_next = {time_reg[TIME_W-BYTE_W-1:0], in_byte};
      end else begin
        trans_reg_next = {trans_reg[TRANS_W-BYTE_W-1:0], in_byte};
      end
      if (hdr_done) begin
        header_count_next = '0;
        in_payload_next   = (length_reg != '0);
        remaining_next    = length_reg;
      end else begin
        header_count_next = header_count + CNT_W'(1);
      end
    end

    res.kind           = pay_mode ? KIND_PAYLOAD : KIND_HEADER;
    res.packet_type    = type_reg;
    res.payload_length = length_reg;
    res.timestamp      = time_reg;
    res.transaction_id = trans_reg_next;
    res.stream_tag     = sid_reg;
    res.payload_byte   = pay_mode ? in_byte : '0;
    res.last           = pay_mode ? (remaining == LEN_W'(1)) : (length_reg == '0);
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_count <= '0;
      type_reg     <= '0;
      length_reg   <= '0;
      time_reg     <= '0;
      trans_reg    <= '0;
      remaining    <= '0;
    end else if (take) begin
      in_payload   <= in_payload_next;
      header_count <= header_count_next;
      type_reg     <= type_reg_next;
      length_reg   <= length_reg_next;
      time_reg     <= time_reg_next;
      trans_reg    <= trans_reg_next;
      remaining    <= remaining_next;
    end
  end

  // Stream id register
  always_ff @(posedge clk) begin
    if (rst) begin
      sid_reg <= '0;
    end else if (cfg_wr) begin
      sid_reg <= cfg_data;
    end
  end

endmodule

[rtl/core/lpfp_out_stage.sv]
// ----------------------------------------------------------------------------
// lpfp_out_stage: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lpfp_out_stage
  import lpfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  input  lpfp_result_t res,
  output logic         out_free,
  output logic         m_tvalid,
  input  logic         m_tready,
  output lpfp_result_t out_res
);

  // Room for a new item when empty or draining now
  assign out_free = !m_tvalid || m_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  // Load result
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

[rtl/core/length_prefixed_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_unit: length-prefixed frame parser
// Splits a byte stream into 17-byte headers and counted payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one raw byte per item. Each 17-byte header
//   (type, 4-byte length, 8-byte timestamp, 4-byte transaction id, all
//   big-endian) yields one header item on the master stream (tuser = 0)
//   with the decoded fields and the configured stream tag. Each following
//   payload byte yields one item (tuser = 1); tlast marks the last byte,
//   or the header itself when the length is zero.
//   The cfg channel writes the stream tag register; it is always ready and
//   should be written only while the stream is idle.
//   Throughput is one byte per cycle while the receiver does not stall. A
//   byte moves from the input register through the parser into the result
//   register, and its item then shows on m_tvalid.
//   When the receiver stalls, the result register holds its item, one more
//   byte is held in the input register, and s_tready then drops until the
//   result is taken. Header bytes that make no item still pass freely.
//   Reset clears both registers, the header count and the stream tag.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit
  import lpfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SID_W-1:0]   cfg_data,    // stream tag [31:0]
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [BYTE_W-1:0]  s_tdata,     // data_byte [7:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  // packet_type [7:0], payload_length [39:8], timestamp [103:40],
  // transaction_id [135:104], stream_tag [167:136], payload_byte [175:168]
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser,     // kind [0]
  output logic               m_tlast
);

  logic              take;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_free;
  logic              res_valid;
  lpfp_result_t      res;
  lpfp_result_t      out_res;

  assign cfg_ready = 1'b1;

  lpfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  lpfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_res   (out_res)
  );

  // Pack the result, first field lowest
  assign m_tdata = {out_res.payload_byte, out_res.stream_tag, out_res.transaction_id,
                    out_res.timestamp, out_res.payload_length, out_res.packet_type};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

[rtl/core/lpfp_checker.sv]
// ----------------------------------------------------------------------------
// lpfp_checker: port-level checks of the frame parser
// Watches the top-level ports and flags stream and framing slips.
// ----------------------------------------------------------------------------
module lpfp_checker
  import lpfp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast
);

  localparam int LEN_LO  = BYTE_W;
  localparam int BYTE_LO = TDATA_W - BYTE_W;

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // No item right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Empty packet ends on its header
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HEADER) &&
    (m_tdata[LEN_LO +: LEN_W] == '0) |-> m_tlast)
    else $error("zero-length header without last");

  // Nonempty header does not end the packet
  a_hdr_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HEADER) &&
    (m_tdata[LEN_LO +: LEN_W] != '0) |-> !m_tlast)
    else $error("nonempty header marked last");

  // Header items carry a zero payload byte
  a_hdr_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HEADER) |-> m_tdata[BYTE_LO +: BYTE_W] == '0)
    else $error("header item with nonzero payload byte");

endmodule

bind length_prefixed_frame_parser_unit lpfp_checker u_lpfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
